/* rtl/core/mpd_pkg.sv */
// Shared types and constants for the mouse packet decoder.
package mpd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned SYNC_BIT_POS  = 3;
   localparam int unsigned X_SIGN_POS    = 4;
   localparam int unsigned Y_SIGN_POS    = 5;
   localparam logic [3:0]  NIBBLE_DOWN   = 4'h1;
   localparam logic [3:0]  NIBBLE_UP     = 4'hF;

   typedef enum logic [1:0] {
      POS_STATUS = 2'd0,
      POS_X      = 2'd1,
      POS_Y      = 2'd2,
      POS_WHEEL  = 2'd3
   } byte_pos_type;

   // One complete, overflow-free packet waiting for formatting.
   typedef struct packed {
      logic       left_button;
      logic       right_button;
      logic       middle_button;
      logic       scroll_down;
      logic       scroll_up;
      logic       x_sign;
      logic       y_sign;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } pkt_type;

   // Handshake between the packet queue and a neighbor.
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

/* rtl/core/mpd_front.sv */
// Front end: byte assembly, sync check, overflow filter and wheel mode register.
module mpd_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   input  logic            csr_write_enable,
   input  logic            csr_write_data,
   output mpd_pkg::hs_type push_hs_o,
   input  logic            push_ready_i,
   output mpd_pkg::pkt_type push_pkt_o
);
   import mpd_pkg::*;

   byte_pos_type pos_ff, pos_in;
   logic         wheel_mode_ff;
   logic [7:0]   status_ff, status_in;
   logic [7:0]   x_ff, x_in;
   logic [7:0]   y_ff, y_in;
   logic         accept;
   logic         done;
   logic [7:0]   y_cur;

   assign req_ready = push_ready_i;
   assign accept    = req_valid & req_ready;

   always_comb begin
      pos_in    = pos_ff;
      status_in = status_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      done      = 1'b0;
      if (accept) begin
         case (pos_ff)
            POS_STATUS: begin
               status_in = req_data_byte;
               pos_in    = req_data_byte[SYNC_BIT_POS] ? POS_X : POS_STATUS;
            end
            POS_X: begin
               x_in   = req_data_byte;
               pos_in = POS_Y;
            end
            POS_Y: begin
               y_in = req_data_byte;
               if (wheel_mode_ff) begin
                  pos_in = POS_WHEEL;
               end else begin
                  pos_in = POS_STATUS;
                  done   = 1'b1;
               end
            end
            POS_WHEEL: begin
               pos_in = POS_STATUS;
               done   = 1'b1;
            end
            default: pos_in = POS_STATUS;
         endcase
      end
   end

   // Y arrives on the completing byte in three-byte mode
   assign y_cur = (pos_ff == POS_Y) ? req_data_byte : y_ff;

   always_comb begin
      push_pkt_o.left_button   = status_ff[0];
      push_pkt_o.right_button  = status_ff[1];
      push_pkt_o.middle_button = status_ff[2];
      push_pkt_o.scroll_down   = wheel_mode_ff && (pos_ff == POS_WHEEL)
                                 && (req_data_byte[3:0] == NIBBLE_DOWN);
      push_pkt_o.scroll_up     = wheel_mode_ff && (pos_ff == POS_WHEEL)
                                 && (req_data_byte[3:0] == NIBBLE_UP);
      push_pkt_o.x_sign        = status_ff[X_SIGN_POS];
      push_pkt_o.y_sign        = status_ff[Y_SIGN_POS];
      push_pkt_o.x_byte        = x_ff;
      push_pkt_o.y_byte        = y_cur;
   end

   assign push_hs_o.valid = done & ~(status_ff[7] | status_ff[6]);
   assign push_hs_o.ready = push_ready_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_STATUS;
         wheel_mode_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (csr_write_enable) begin
            wheel_mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
   end

endmodule

/* rtl/core/mpd_queue.sv */
// Short packet queue between the front and back ends.
module mpd_queue #(
   parameter int unsigned DEPTH = mpd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid_i,
   output logic             push_ready_o,
   input  mpd_pkg::pkt_type push_pkt_i,
   output logic             pop_valid_o,
   input  logic             pop_ready_i,
   output mpd_pkg::pkt_type pop_pkt_o
);
   import mpd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pkt_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign push_ready_o = (count_ff != CNT_W'(DEPTH));
   assign pop_valid_o  = (count_ff != '0);
   assign pop_pkt_o    = slot_ff[rd_ptr_ff];
   assign push         = push_valid_i & push_ready_o;
   assign pop          = pop_valid_o & pop_ready_i;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_pkt_i;
      end
   end

endmodule

/* rtl/core/mpd_back.sv */
// Back end: motion formatting and the registered result channel.
module mpd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid_i,
   output logic             pop_ready_o,
   input  mpd_pkg::pkt_type pop_pkt_i,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_left_button,
   output logic             rsp_right_button,
   output logic             rsp_middle_button,
   output logic             rsp_scroll_down,
   output logic             rsp_scroll_up,
   output logic signed [8:0] rsp_motion_x,
   output logic signed [9:0] rsp_motion_y
);
   import mpd_pkg::*;

   logic              valid_ff;
   logic              load;
   logic [8:0]        mx_in;
   logic [9:0]        my_in;
   logic [8:0]        mx_ff;
   logic [9:0]        my_ff;
   logic [4:0]        flags_ff;

   assign pop_ready_o = ~valid_ff | rsp_ready;
   assign load        = pop_valid_i & pop_ready_o;

   // X: sign bit prepended. Y: 256 * sign minus the byte, so down is positive.
   assign mx_in = {pop_pkt_i.x_sign, pop_pkt_i.x_byte};
   assign my_in = {1'b0, pop_pkt_i.y_sign, 8'h00} - {2'b00, pop_pkt_i.y_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready_o) begin
         valid_ff <= pop_valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         flags_ff <= {pop_pkt_i.left_button, pop_pkt_i.right_button,
                      pop_pkt_i.middle_button, pop_pkt_i.scroll_down,
                      pop_pkt_i.scroll_up};
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_left_button   = flags_ff[4];
   assign rsp_right_button  = flags_ff[3];
   assign rsp_middle_button = flags_ff[2];
   assign rsp_scroll_down   = flags_ff[1];
   assign rsp_scroll_up     = flags_ff[0];
   assign rsp_motion_x      = mx_ff;
   assign rsp_motion_y      = my_ff;

endmodule

/* rtl/core/mouse_packet_decoder_unit.sv */
// Top level of the mouse packet decoder.
//
// Raw mouse bytes enter on the req_ channel (valid/ready), one byte per
// transfer. A packet is status, X and Y bytes, plus a wheel byte when the
// wheel mode bit (csr_write_enable / csr_write_data) is set. A status byte
// with bit 3 clear is dropped; a packet with an overflow bit set gives no
// result. Every other packet gives one transfer on the rsp_ channel.
//
// Throughput: one byte per cycle while the packet queue is not full. The
// last byte of a packet enters a short packet queue at the edge that takes
// it; the result register then loads the packet from the queue, and
// rsp_valid is driven from that register.
// req_ready drops only while the packet queue is full, which takes a
// receiver that holds rsp_ready low for several packets.
// Reset clears the byte position, the wheel mode bit, the queue and the
// result valid; the stored packet bytes are not cleared.
// While the receiver stalls, the pending result holds its value.
module mouse_packet_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = mpd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_left_button,
   output logic              rsp_right_button,
   output logic              rsp_middle_button,
   output logic              rsp_scroll_down,
   output logic              rsp_scroll_up,
   output logic signed [8:0] rsp_motion_x,
   output logic signed [9:0] rsp_motion_y
);
   import mpd_pkg::*;

   hs_type  push_hs;
   logic    push_ready;
   pkt_type push_pkt;
   logic    pop_valid;
   logic    pop_ready;
   pkt_type pop_pkt;

   mpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_hs_o        (push_hs),
      .push_ready_i     (push_ready),
      .push_pkt_o       (push_pkt)
   );

   mpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid_i (push_hs.valid & push_hs.ready),
      .push_ready_o (push_ready),
      .push_pkt_i   (push_pkt),
      .pop_valid_o  (pop_valid),
      .pop_ready_i  (pop_ready),
      .pop_pkt_o    (pop_pkt)
   );

   mpd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid_i       (pop_valid),
      .pop_ready_o       (pop_ready),
      .pop_pkt_i         (pop_pkt),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button),
      .rsp_scroll_down   (rsp_scroll_down),
      .rsp_scroll_up     (rsp_scroll_up),
      .rsp_motion_x      (rsp_motion_x),
      .rsp_motion_y      (rsp_motion_y)
   );

endmodule
